>>> rtl/sfm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfm_pkg
// Shared constants and types of the substring first-match search block.
// ---------------------------------------------------------------------------
package sfm_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POS_BITS      = 16;
    // the pattern registers carry at most sixteen bytes
    localparam int NUM_CELLS     = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
    localparam int IDX_BITS      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int OFFSET_BITS   = 16;
    localparam int OFFSET_MAX    = 65535;
    localparam int LEN_BITS      = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH = 2'd2;

    // handed from one cell to the next
    typedef struct packed {
        logic en;   // this and all lower pattern bytes are in use
        logic hit;  // stored prefix-match bit
    } sfm_link_t;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
    } sfm_result_t;

endpackage : sfm_pkg
`default_nettype wire

>>> rtl/substring_first_match_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// substring_first_match_unit
// Streaming first-occurrence substring search over a configured pattern.
// ---------------------------------------------------------------------------
// Text arrives one non-zero byte per input beat and closes with an
// end-of-text beat (end_of_text high, or a zero byte). The block takes one
// beat every clock while in_stall is low: a row of sixteen cells, one per
// pattern byte, each keeps one prefix-match bit and feeds it to its right
// neighbor, so a byte is settled in the cycle it is accepted. The first
// full match of a text gives one result beat (found, start offset,
// saturating at 65535); a text with no match gives found=0 on its end beat,
// and an empty pattern gives found at offset 0 on the first beat. Results
// pass through an output register and a one-beat skid stage; in_stall rises
// only when both hold a beat. The pattern registers take writes at any
// cycle (cfg_ready is always high) and should be written only between texts.
// ---------------------------------------------------------------------------
module substring_first_match_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // text beats
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [7:0]                          text_byte,
    input  wire logic                                end_of_text,
    // result beats
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic [sfm_pkg::OFFSET_BITS-1:0]          match_offset,
    // register writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [sfm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int NC = sfm_pkg::NUM_CELLS;
    localparam int PB = sfm_pkg::POS_BITS;

    // configuration registers
    logic [sfm_pkg::LEN_BITS-1:0]      pattern_len_reg;
    logic [sfm_pkg::CFG_DATA_BITS-1:0] pattern_low_reg;
    logic [sfm_pkg::CFG_DATA_BITS-1:0] pattern_high_reg;
    logic [2*sfm_pkg::CFG_DATA_BITS-1:0] pattern_all;

    // text state
    logic [PB-1:0] pos_reg;
    logic [PB-1:0] pos_next;
    logic          reported_reg;
    logic          reported_next;

    logic accept;
    logic is_end;
    logic advance;
    logic clear;

    sfm_pkg::sfm_link_t link [NC+1];
    logic [NC-1:0]       en_vec;
    logic [NC-1:0]       last_vec;
    logic [NC-1:0]       hit_vec;
    logic [sfm_pkg::IDX_BITS-1:0] last_idx;
    logic                         full_match;
    logic                         empty_pat;
    logic [PB-1:0]                start_pos;
    logic [sfm_pkg::OFFSET_BITS-1:0] start_off;

    logic                 res_valid;
    sfm_pkg::sfm_result_t res;
    sfm_pkg::sfm_result_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg  <= '0;
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sfm_pkg::REG_PATTERN_LEN:
                begin
                    pattern_len_reg <= cfg_data[sfm_pkg::LEN_BITS-1:0];
                end
                sfm_pkg::REG_PATTERN_LOW:
                begin
                    pattern_low_reg <= cfg_data;
                end
                sfm_pkg::REG_PATTERN_HIGH:
                begin
                    pattern_high_reg <= cfg_data;
                end
                default:
                begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    assign accept  = in_valid & ~in_stall;
    // a zero byte closes the text just like the marker
    assign is_end  = end_of_text | (text_byte == 8'd0);
    assign empty_pat = ~en_vec[0];
    assign clear   = accept & is_end;
    // prefix bits move only while a text is still searching
    assign advance = accept & ~is_end & ~reported_reg & ~empty_pat;

    // head of the chain: byte 0 always has a satisfied predecessor
    assign link[0].en  = 1'b1;
    assign link[0].hit = 1'b1;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        sfm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .clear     (clear),
            .cap_ok    (pattern_len_reg > sfm_pkg::LEN_BITS'(k)),
            .pat_byte  (pattern_all[8*k +: 8]),
            .text_byte (text_byte),
            .link_in   (link[k]),
            .link_out  (link[k+1]),
            .hit_next  (hit_vec[k])
        );
        assign en_vec[k] = link[k+1].en;
    end

    // one-hot mark of the last pattern byte in use
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            if (k == NC - 1)
            begin
                last_vec[k] = en_vec[k];
            end
            else
            begin
                last_vec[k] = en_vec[k] & ~en_vec[k+1];
            end
        end
    end

    always_comb
    begin
        last_idx = '0;
        for (int k = 0; k < NC; k++)
        begin
            if (last_vec[k])
            begin
                last_idx = last_idx | sfm_pkg::IDX_BITS'(k);
            end
        end
    end

    assign full_match = |(hit_vec & last_vec);

    // start of the match: current position less (length - 1), floored at zero
    always_comb
    begin
        if (pos_reg >= PB'(last_idx))
        begin
            start_pos = pos_reg - PB'(last_idx);
        end
        else
        begin
            start_pos = '0;
        end
        if (32'(start_pos) > 32'(sfm_pkg::OFFSET_MAX))
        begin
            start_off = sfm_pkg::OFFSET_BITS'(sfm_pkg::OFFSET_MAX);
        end
        else
        begin
            start_off = sfm_pkg::OFFSET_BITS'(start_pos);
        end
    end

    // result of the accepted beat and next text state
    always_comb
    begin
        res_valid     = 1'b0;
        res.found     = 1'b0;
        res.offset    = '0;
        reported_next = reported_reg;
        pos_next      = pos_reg;
        if (accept)
        begin
            if (is_end)
            begin
                res_valid     = ~reported_reg;
                res.found     = empty_pat;
                reported_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                if (pos_reg != {PB{1'b1}})
                begin
                    pos_next = pos_reg + PB'(1);
                end
                if (!reported_reg)
                begin
                    if (empty_pat)
                    begin
                        res_valid     = 1'b1;
                        res.found     = 1'b1;
                        reported_next = 1'b1;
                    end
                    else if (full_match)
                    begin
                        res_valid     = 1'b1;
                        res.found     = 1'b1;
                        res.offset    = start_off;
                        reported_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
        end
    end

    sfm_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .in_stall  (in_stall)
    );

    assign found        = out_res.found;
    assign match_offset = out_res.offset;

endmodule : substring_first_match_unit
`default_nettype wire

>>> rtl/sfm_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfm_cell
// One pattern position: compares its byte and keeps one prefix-match bit.
// ---------------------------------------------------------------------------
module sfm_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              clear,
    input  wire logic              cap_ok,
    input  wire logic [7:0]        pat_byte,
    input  wire logic [7:0]        text_byte,
    input  wire sfm_pkg::sfm_link_t link_in,
    output sfm_pkg::sfm_link_t     link_out,
    output logic                   hit_next
);

    logic hit_reg;
    logic en;

    assign en       = link_in.en & cap_ok & (pat_byte != 8'd0);
    assign hit_next = en & link_in.hit & (pat_byte == text_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            hit_reg <= hit_next;
        end
    end

    assign link_out.en  = en;
    assign link_out.hit = hit_reg;

endmodule : sfm_cell
`default_nettype wire

>>> rtl/sfm_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfm_out_buf
// Output register with one skid stage for result beats.
// ---------------------------------------------------------------------------
module sfm_out_buf
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                res_valid,
    input  wire sfm_pkg::sfm_result_t res,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output sfm_pkg::sfm_result_t     out_res,
    output logic                     in_stall
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    sfm_pkg::sfm_result_t out_reg;
    sfm_pkg::sfm_result_t skid_reg;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg  <= skid_valid_reg | res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    // hold input while the skid stage holds a beat
    assign in_stall  = skid_valid_reg;

endmodule : sfm_out_buf
`default_nettype wire

>>> rtl/sfm_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sfm_checker
// Port-level checks of the substring first-match search block.
// ---------------------------------------------------------------------------
module sfm_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic                               found,
    input wire logic [sfm_pkg::OFFSET_BITS-1:0]    match_offset
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_offset))
        else $error("result beat changed while stalled");

    // input stall only while a result waits at the output
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // input stall starts only after the output was held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without held output");

    // a miss carries offset zero
    a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("not-found beat with non-zero offset");

endmodule : sfm_checker

bind substring_first_match_unit sfm_checker u_sfm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .match_offset (match_offset)
);
`default_nettype wire
